// ----- hdl/csl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the C-style lexer unit.
// No dependencies; imported by every other module of the block.
package csl_pkg;

  localparam int unsigned POS_BITS_DEF    = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned TYPE_W = 5;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned OUT_W  = 16;

  // Punctuation token codes
  localparam logic [TYPE_W-1:0] PT_COLON  = 5'd0;
  localparam logic [TYPE_W-1:0] PT_SEMI   = 5'd1;
  localparam logic [TYPE_W-1:0] PT_COMMA  = 5'd2;
  localparam logic [TYPE_W-1:0] PT_STAR   = 5'd3;
  localparam logic [TYPE_W-1:0] PT_HASH   = 5'd4;
  localparam logic [TYPE_W-1:0] PT_DOT    = 5'd5;
  localparam logic [TYPE_W-1:0] PT_LPAREN = 5'd6;
  localparam logic [TYPE_W-1:0] PT_RPAREN = 5'd7;
  localparam logic [TYPE_W-1:0] PT_LBRACE = 5'd8;
  localparam logic [TYPE_W-1:0] PT_RBRACE = 5'd9;
  localparam logic [TYPE_W-1:0] PT_LBRACK = 5'd10;
  localparam logic [TYPE_W-1:0] PT_RBRACK = 5'd11;

  // Token type codes
  localparam logic [TYPE_W-1:0] TT_END     = 5'd12;
  localparam logic [TYPE_W-1:0] TT_CHAR    = 5'd13;
  localparam logic [TYPE_W-1:0] TT_STRING  = 5'd14;
  localparam logic [TYPE_W-1:0] TT_IDENT   = 5'd15;
  localparam logic [TYPE_W-1:0] TT_UNKNOWN = 5'd16;

  typedef struct packed {
    logic [TYPE_W-1:0] ttype;
    logic [OUT_W-1:0]  start;
    logic [LEN_W-1:0]  length;
  } token_t;

  // Tokens caused by one input byte: one or two
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

endpackage

// ----- hdl/c_style_lexer_unit.sv -----
`timescale 1ns / 1ps
// Top level of the C-style lexer unit: front end, entry queue, output stage.
// Depends on csl_pkg, csl_front, csl_queue and csl_back.

// One text byte is taken per clock as long as the entry queue has room; a
// byte yields zero, one or two tokens, and the output stage presents one
// token per clock from its output register while the token side is ready.
// A token passes the entry queue and then the output register, and the
// second token of a pair leaves that register after the first. The output
// stage sets the sustained rate: a run of bytes giving two tokens each drains
// at one token per clock, and the input then waits once the QUEUE_DEPTH-entry
// queue is full. Byte offsets count modulo 2**POS_BITS and are reported in
// 16 bits; a NUL byte emits an end token and restarts the offset at zero.
module c_style_lexer_unit import csl_pkg::*; #(
  parameter int unsigned POS_BITS    = POS_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        char_in_i,
  input  logic              char_in_valid_i,
  output logic              char_in_ready_o,
  output logic [TYPE_W-1:0] token_type_o,
  output logic [OUT_W-1:0]  token_start_o,
  output logic [LEN_W-1:0]  token_length_o,
  output logic              last_o,
  output logic              token_valid_o,
  input  logic              token_ready_i
);

  logic   push, pop, full, empty;
  entry_t push_entry, head;
  token_t tok;

  csl_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .char_in_i       (char_in_i),
    .char_in_valid_i (char_in_valid_i),
    .char_in_ready_o (char_in_ready_o),
    .queue_full_i    (full),
    .push_o          (push),
    .push_entry_o    (push_entry)
  );

  csl_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (full),
    .empty_o      (empty),
    .head_o       (head)
  );

  csl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .tok_o   (tok),
    .last_o  (last_o),
    .valid_o (token_valid_o),
    .ready_i (token_ready_i)
  );

  assign token_type_o   = tok.ttype;
  assign token_start_o  = tok.start;
  assign token_length_o = tok.length;

endmodule

// ----- hdl/csl_front.sv -----
`timescale 1ns / 1ps
// Lexer front end, depends on csl_pkg: accepts one byte per cycle while the
// queue has room, runs the mode machine and packs its tokens in one entry.
module csl_front import csl_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   char_in_i,
  input  logic         char_in_valid_i,
  output logic         char_in_ready_o,
  input  logic         queue_full_i,
  output logic         push_o,
  output entry_t       push_entry_o
);

  localparam logic [2:0] M_NORMAL     = 3'd0;
  localparam logic [2:0] M_SLASH      = 3'd1;
  localparam logic [2:0] M_LINE       = 3'd2;
  localparam logic [2:0] M_BLOCK      = 3'd3;
  localparam logic [2:0] M_BLOCK_STAR = 3'd4;
  localparam logic [2:0] M_IDENT      = 3'd5;
  localparam logic [2:0] M_STRING     = 3'd6;
  localparam logic [2:0] M_CHAR       = 3'd7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;

  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  logic [2:0]          mode_q, mode_d;
  logic                esc_q, esc_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] ps_q, ps_d;
  logic [LEN_W-1:0]    pl_q, pl_d;

  logic                accept;
  logic [7:0]          c;
  logic                is_ws, is_alpha, is_digit, is_word, is_punct;
  logic [TYPE_W-1:0]   punct_type;
  logic [POS_BITS-1:0] pos_inc;
  logic [LEN_W-1:0]    pl_inc;
  logic [OUT_W-1:0]    pos_out, ps_out;

  // normal-mode handling of the current byte
  logic [2:0]          nb_mode;
  logic                nb_esc;
  logic [POS_BITS-1:0] nb_ps;
  logic [LEN_W-1:0]    nb_pl;
  logic                nb_v;
  token_t              nb_tok;

  logic                pre_v, sec_v;
  token_t              pre_tok, sec_tok;

  assign accept          = char_in_valid_i & ~queue_full_i;
  assign char_in_ready_o = ~queue_full_i;
  assign c               = char_in_i;
  assign pos_inc         = pos_q + POS_BITS'(1);
  assign pl_inc          = (pl_q == LEN_MAX) ? pl_q : pl_q + LEN_ONE;
  assign pos_out         = OUT_W'(32'(pos_q));
  assign ps_out          = OUT_W'(32'(ps_q));

  always_comb begin
    is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    is_alpha = c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    is_digit = c inside {[8'h30:8'h39]};
    is_word  = is_alpha | is_digit | (c == CH_UNDER);
    is_punct = 1'b1;
    case (c)
      8'h3a:   punct_type = PT_COLON;   // :
      8'h3b:   punct_type = PT_SEMI;    // ;
      8'h2c:   punct_type = PT_COMMA;   // ,
      8'h2a:   punct_type = PT_STAR;    // *
      8'h23:   punct_type = PT_HASH;    // #
      8'h2e:   punct_type = PT_DOT;     // .
      8'h28:   punct_type = PT_LPAREN;  // (
      8'h29:   punct_type = PT_RPAREN;  // )
      8'h7b:   punct_type = PT_LBRACE;  // {
      8'h7d:   punct_type = PT_RBRACE;  // }
      8'h5b:   punct_type = PT_LBRACK;  // [
      8'h5d:   punct_type = PT_RBRACK;  // ]
      default: begin
        punct_type = TT_UNKNOWN;
        is_punct   = 1'b0;
      end
    endcase
  end

  always_comb begin
    nb_mode       = M_NORMAL;
    nb_esc        = esc_q;
    nb_ps         = ps_q;
    nb_pl         = pl_q;
    nb_v          = 1'b0;
    nb_tok.ttype  = TT_UNKNOWN;
    nb_tok.start  = pos_out;
    nb_tok.length = LEN_ONE;
    if (is_ws) begin
      nb_v = 1'b0;
    end else if (is_punct) begin
      nb_v         = 1'b1;
      nb_tok.ttype = punct_type;
    end else if (c == CH_SLASH) begin
      nb_mode = M_SLASH;
      nb_ps   = pos_q;
    end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
      nb_mode = (c == CH_DQUOTE) ? M_STRING : M_CHAR;
      nb_esc  = 1'b0;
      nb_ps   = pos_inc;  // literal span starts after the quote
      nb_pl   = '0;
    end else if (is_alpha || (c == CH_UNDER)) begin
      nb_mode = M_IDENT;
      nb_ps   = pos_q;
      nb_pl   = LEN_ONE;
    end else if (is_digit) begin
      nb_v         = 1'b1;
      nb_tok.ttype = TT_IDENT;
    end else begin
      nb_v = 1'b1;
    end
  end

  always_comb begin
    mode_d         = mode_q;
    esc_d          = esc_q;
    pos_d          = pos_inc;
    ps_d           = ps_q;
    pl_d           = pl_q;
    pre_v          = 1'b0;
    pre_tok.ttype  = TT_UNKNOWN;
    pre_tok.start  = ps_out;
    pre_tok.length = LEN_ONE;
    sec_v          = 1'b0;
    sec_tok        = nb_tok;

    if (c == CH_NUL) begin
      // end of stream: flush a pending slash or identifier, drop open literals
      if (mode_q == M_SLASH) begin
        pre_v = 1'b1;
      end else if (mode_q == M_IDENT) begin
        pre_v          = 1'b1;
        pre_tok.ttype  = TT_IDENT;
        pre_tok.length = pl_q;
      end
      sec_v          = 1'b1;
      sec_tok.ttype  = TT_END;
      sec_tok.start  = pos_out;
      sec_tok.length = LEN_ONE;
      mode_d         = M_NORMAL;
      esc_d          = 1'b0;
      pl_d           = '0;
      pos_d          = '0;
    end else begin
      case (mode_q)
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_d = M_LINE;
          end else if (c == CH_STAR) begin
            mode_d = M_BLOCK;
          end else begin
            pre_v  = 1'b1;
            sec_v  = nb_v;
            mode_d = nb_mode;
            esc_d  = nb_esc;
            ps_d   = nb_ps;
            pl_d   = nb_pl;
          end
        end
        M_LINE: begin
          if ((c == CH_CR) || (c == CH_LF)) begin
            mode_d = M_NORMAL;
          end
        end
        M_BLOCK: begin
          if (c == CH_STAR) begin
            mode_d = M_BLOCK_STAR;
          end
        end
        M_BLOCK_STAR: begin
          if (c == CH_SLASH) begin
            mode_d = M_NORMAL;
          end else if (c != CH_STAR) begin
            mode_d = M_BLOCK;
          end
        end
        M_IDENT: begin
          if (is_word) begin
            pl_d = pl_inc;
          end else begin
            pre_v          = 1'b1;
            pre_tok.ttype  = TT_IDENT;
            pre_tok.length = pl_q;
            sec_v          = nb_v;
            mode_d         = nb_mode;
            esc_d          = nb_esc;
            ps_d           = nb_ps;
            pl_d           = nb_pl;
          end
        end
        M_STRING, M_CHAR: begin
          if (esc_q) begin
            esc_d = 1'b0;
            pl_d  = pl_inc;
          end else if (c == CH_BSLASH) begin
            esc_d = 1'b1;
            pl_d  = pl_inc;
          end else if (c == ((mode_q == M_STRING) ? CH_DQUOTE : CH_SQUOTE)) begin
            pre_v          = 1'b1;
            pre_tok.ttype  = (mode_q == M_STRING) ? TT_STRING : TT_CHAR;
            pre_tok.length = pl_q;
            mode_d         = M_NORMAL;
          end else begin
            pl_d = pl_inc;
          end
        end
        default: begin
          sec_v  = nb_v;
          mode_d = nb_mode;
          esc_d  = nb_esc;
          ps_d   = nb_ps;
          pl_d   = nb_pl;
        end
      endcase
    end
  end

  assign push_o            = accept & (pre_v | sec_v);
  assign push_entry_o.two  = pre_v & sec_v;
  assign push_entry_o.tok0 = pre_v ? pre_tok : sec_tok;
  assign push_entry_o.tok1 = sec_tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NORMAL;
      esc_q  <= 1'b0;
      pos_q  <= '0;
      ps_q   <= '0;
      pl_q   <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
      pos_q  <= pos_d;
      ps_q   <= ps_d;
      pl_q   <= pl_d;
    end
  end

endmodule

// ----- hdl/csl_queue.sv -----
`timescale 1ns / 1ps
// Small FIFO of token entries between lexer front end and output stage.
// Depends on csl_pkg.
module csl_queue import csl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [IDX_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == IDX_LAST) ? '0 : wr_q + IDX_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == IDX_LAST) ? '0 : rd_q + IDX_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hdl/csl_back.sv -----
`timescale 1ns / 1ps
// Output stage: splits queue entries into single tokens and holds each one
// in an output register until taken. Depends on csl_pkg.
module csl_back import csl_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   empty_i,
  input  entry_t head_i,
  output logic   pop_o,
  output token_t tok_o,
  output logic   last_o,
  output logic   valid_o,
  input  logic   ready_i
);

  logic   sel_q, sel_d;
  logic   out_v_q, out_v_d;
  token_t tok_q, tok_d;
  logic   last_q, last_d;
  logic   load;

  assign load = ~empty_i & (~out_v_q | ready_i);

  always_comb begin
    sel_d   = sel_q;
    tok_d   = tok_q;
    last_d  = last_q;
    out_v_d = out_v_q & ~ready_i;
    pop_o   = 1'b0;
    if (load) begin
      out_v_d = 1'b1;
      tok_d   = sel_q ? head_i.tok1 : head_i.tok0;
      last_d  = ~head_i.two | sel_q;
      // second token of a pair still to come: keep the entry
      if (head_i.two && !sel_q) begin
        sel_d = 1'b1;
      end else begin
        sel_d = 1'b0;
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      sel_q   <= sel_d;
      out_v_q <= out_v_d;
    end
  end

  assign tok_o   = tok_q;
  assign last_o  = last_q;
  assign valid_o = out_v_q;

endmodule

// ----- verif/tb_c_style_lexer_unit.sv -----
`timescale 1ns / 1ps
// Testbench for c_style_lexer_unit: streams text bytes in and checks each token
// against an in-bench model of the lexer. Depends on csl_pkg and the RTL top.
module tb_c_style_lexer_unit;
  import csl_pkg::*;

  localparam int unsigned TIMEOUT_NS   = 10_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 1350;

  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  typedef enum logic [3:0] {
    LX_NORMAL, LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR, LX_IDENT, LX_STRING, LX_CHAR
  } lex_mode_e;

  typedef struct packed {
    logic [TYPE_W-1:0] ttype;
    logic [OUT_W-1:0]  start;
    logic [LEN_W-1:0]  length;
    logic              last;
  } lex_token_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic [7:0]        char_in_i = 8'h00;
  logic              char_in_valid_i = 1'b0;
  logic              char_in_ready_o;
  logic [TYPE_W-1:0] token_type_o;
  logic [OUT_W-1:0]  token_start_o;
  logic [LEN_W-1:0]  token_length_o;
  logic              last_o;
  logic              token_valid_o;
  logic              token_ready_i = 1'b0;

  c_style_lexer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .char_in_i       (char_in_i),
    .char_in_valid_i (char_in_valid_i),
    .char_in_ready_o (char_in_ready_o),
    .token_type_o    (token_type_o),
    .token_start_o   (token_start_o),
    .token_length_o  (token_length_o),
    .last_o          (last_o),
    .token_valid_o   (token_valid_o),
    .token_ready_i   (token_ready_i)
  );

  always #5 clk_i = ~clk_i;

  // Lexer model state
  lex_mode_e         lx_mode = LX_NORMAL;
  logic              lx_escape = 1'b0;
  logic [OUT_W-1:0]  lx_pos = '0;
  logic [OUT_W-1:0]  lx_start = '0;
  logic [LEN_W-1:0]  lx_len = '0;
  lex_token_t        step_toks [2];
  int                step_n;

  lex_token_t        tokens_due [$];
  int                in_gap_max = 0;
  int                out_gap_max = 0;
  int                stall_left = 0;
  int                mismatch_cnt = 0;
  int                bytes_sent = 0;
  int                tokens_seen = 0;
  string             punct_set = ":;,*#.()[]{}";

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [LEN_W-1:0] sat_inc(logic [LEN_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void emit_token(logic [TYPE_W-1:0] t, logic [OUT_W-1:0] s,
                                     logic [LEN_W-1:0] l);
    step_toks[step_n] = '{ttype: t, start: s, length: l, last: 1'b0};
    step_n++;
  endfunction

  function automatic void lex_normal(logic [7:0] c, logic [OUT_W-1:0] pos);
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
      ":": emit_token(PT_COLON, pos, LEN_ONE);
      ";": emit_token(PT_SEMI, pos, LEN_ONE);
      ",": emit_token(PT_COMMA, pos, LEN_ONE);
      "*": emit_token(PT_STAR, pos, LEN_ONE);
      "#": emit_token(PT_HASH, pos, LEN_ONE);
      ".": emit_token(PT_DOT, pos, LEN_ONE);
      "(": emit_token(PT_LPAREN, pos, LEN_ONE);
      ")": emit_token(PT_RPAREN, pos, LEN_ONE);
      "{": emit_token(PT_LBRACE, pos, LEN_ONE);
      "}": emit_token(PT_RBRACE, pos, LEN_ONE);
      "[": emit_token(PT_LBRACK, pos, LEN_ONE);
      "]": emit_token(PT_RBRACK, pos, LEN_ONE);
      CH_SLASH: begin
        lx_mode  = LX_SLASH;
        lx_start = pos;
      end
      CH_DQUOTE, CH_SQUOTE: begin
        lx_mode   = (c == CH_DQUOTE) ? LX_STRING : LX_CHAR;
        lx_escape = 1'b0;
        lx_start  = pos + 1'b1;
        lx_len    = '0;
      end
      default: begin
        if (is_alpha(c) || c == CH_USCORE) begin
          lx_mode  = LX_IDENT;
          lx_start = pos;
          lx_len   = LEN_ONE;
        end else if (is_digit(c)) begin
          emit_token(TT_IDENT, pos, LEN_ONE);
        end else begin
          emit_token(TT_UNKNOWN, pos, LEN_ONE);
        end
      end
    endcase
  endfunction

  // Advance the model by one byte and queue the tokens it yields
  function automatic void lex_byte(logic [7:0] c);
    logic [OUT_W-1:0] pos;
    lex_token_t       tok;
    pos    = lx_pos;
    step_n = 0;
    if (c == CH_NUL) begin
      if (lx_mode == LX_SLASH) emit_token(TT_UNKNOWN, lx_start, LEN_ONE);
      else if (lx_mode == LX_IDENT) emit_token(TT_IDENT, lx_start, lx_len);
      emit_token(TT_END, pos, LEN_ONE);
      lx_mode   = LX_NORMAL;
      lx_escape = 1'b0;
      lx_len    = '0;
      lx_pos    = '0;
    end else begin
      case (lx_mode)
        LX_SLASH: begin
          if (c == CH_SLASH) lx_mode = LX_LINE;
          else if (c == CH_STAR) lx_mode = LX_BLOCK;
          else begin
            emit_token(TT_UNKNOWN, lx_start, LEN_ONE);
            lx_mode = LX_NORMAL;
            lex_normal(c, pos);
          end
        end
        LX_LINE: if (c == CH_CR || c == CH_LF) lx_mode = LX_NORMAL;
        LX_BLOCK: if (c == CH_STAR) lx_mode = LX_BLOCK_STAR;
        LX_BLOCK_STAR: begin
          if (c == CH_SLASH) lx_mode = LX_NORMAL;
          else if (c != CH_STAR) lx_mode = LX_BLOCK;
        end
        LX_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == CH_USCORE) begin
            lx_len = sat_inc(lx_len);
          end else begin
            emit_token(TT_IDENT, lx_start, lx_len);
            lx_mode = LX_NORMAL;
            lex_normal(c, pos);
          end
        end
        LX_STRING, LX_CHAR: begin
          if (lx_escape) begin
            lx_escape = 1'b0;
            lx_len    = sat_inc(lx_len);
          end else if (c == CH_BSLASH) begin
            lx_escape = 1'b1;
            lx_len    = sat_inc(lx_len);
          end else if (c == ((lx_mode == LX_STRING) ? CH_DQUOTE : CH_SQUOTE)) begin
            emit_token((lx_mode == LX_STRING) ? TT_STRING : TT_CHAR, lx_start, lx_len);
            lx_mode = LX_NORMAL;
          end else begin
            lx_len = sat_inc(lx_len);
          end
        end
        default: begin
          lx_mode = LX_NORMAL;
          lex_normal(c, pos);
        end
      endcase
      lx_pos = pos + 1'b1;
    end
    for (int i = 0; i < step_n; i++) begin
      tok      = step_toks[i];
      tok.last = (i == step_n - 1);
      tokens_due.push_back(tok);
    end
  endfunction

  // Token side: check every transaction, then stall ready for a drawn count
  always @(posedge clk_i) begin
    lex_token_t want;
    if (rst_ni && token_valid_o && token_ready_i) begin
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        $error("unexpected token: type %0d start %0d length %0d",
               token_type_o, token_start_o, token_length_o);
        mismatch_cnt++;
      end else begin
        want = tokens_due.pop_front();
        if (token_type_o !== want.ttype) begin
          $error("token_type: expected %0d, got %0d", want.ttype, token_type_o);
          mismatch_cnt++;
        end
        if (token_start_o !== want.start) begin
          $error("token_start: expected %0d, got %0d", want.start, token_start_o);
          mismatch_cnt++;
        end
        if (token_length_o !== want.length) begin
          $error("token_length: expected %0d, got %0d", want.length, token_length_o);
          mismatch_cnt++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          mismatch_cnt++;
        end
      end
      stall_left = (out_gap_max > 0) ? $urandom_range(0, out_gap_max) : 0;
      if (stall_left > 0) token_ready_i <= 1'b0;
    end else if (!token_ready_i) begin
      if (stall_left <= 1) token_ready_i <= 1'b1;
      stall_left--;
    end
  end

  // Send one byte; valid stays high across back-to-back transactions
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
    if (gap > 0) begin
      char_in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_in_i       <= b;
    char_in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!char_in_ready_o) @(posedge clk_i);
    lex_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_text_byte(logic [7:0] skip_a, logic [7:0] skip_b);
    logic [7:0] v;
    do v = 8'($urandom_range(1, 255)); while (v == skip_a || v == skip_b);
    return v;
  endfunction

  function automatic logic [7:0] rand_word_char();
    int k;
    k = $urandom_range(0, 62);
    if (k < 26) return 8'("a" + k);
    if (k < 52) return 8'("A" + (k - 26));
    if (k < 62) return 8'("0" + (k - 52));
    return CH_USCORE;
  endfunction

  task automatic test_punctuation();
    send_text(punct_set);
  endtask

  task automatic test_identifiers();
    // space ends an ident; ';' ends one and is a token too; digit alone; stray byte
    send_text("_9 b;7");
    send_byte(8'hFF);
  endtask

  task automatic test_literals();
    send_text("\"\\\"\"'a'");
  endtask

  task automatic test_comments();
    // opening slash-star must not close the block; lone slash then ';'
    send_text("/*/**/");
    send_text("//\n/;");
  endtask

  task automatic test_end_of_stream();
    send_text("/*");
    send_byte(CH_NUL);
    send_text("\"\\");
    send_byte(CH_NUL);
    send_text("ab");
    send_byte(CH_NUL);
    send_text("/");
    send_byte(CH_NUL);
  endtask

  task automatic send_fragment();
    int kind;
    int n;
    kind = $urandom_range(0, 15);
    case (kind)
      0, 12, 13: begin
        send_byte(($urandom_range(0, 5) == 0) ? CH_USCORE : 8'("a" + $urandom_range(0, 25)));
        n = $urandom_range(0, 9);
        repeat (n) send_byte(rand_word_char());
      end
      1: send_byte(8'("0" + $urandom_range(0, 9)));
      2, 14: send_byte(punct_set[$urandom_range(0, 11)]);
      3: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: send_byte(CH_SPACE);
            1: send_byte(CH_TAB);
            2: send_byte(CH_CR);
            default: send_byte(CH_LF);
          endcase
        end
      end
      4, 15: begin
        send_byte(CH_DQUOTE);
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            send_byte(CH_BSLASH);
            send_byte(rand_text_byte(CH_NUL, CH_NUL));
          end else begin
            send_byte(rand_text_byte(CH_DQUOTE, CH_BSLASH));
          end
        end
        send_byte(CH_DQUOTE);
      end
      5: begin
        send_byte(CH_SQUOTE);
        if ($urandom_range(0, 2) == 0) begin
          send_byte(CH_BSLASH);
          send_byte(rand_text_byte(CH_NUL, CH_NUL));
        end else begin
          send_byte(rand_text_byte(CH_SQUOTE, CH_BSLASH));
        end
        send_byte(CH_SQUOTE);
      end
      6: begin
        send_text("//");
        n = $urandom_range(0, 6);
        repeat (n) send_byte(rand_text_byte(CH_CR, CH_LF));
        send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
      end
      7: begin
        send_text("/*");
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: send_byte(CH_STAR);
            1: send_byte(CH_SLASH);
            default: send_byte(rand_text_byte(CH_STAR, CH_SLASH));
          endcase
        end
        if ($urandom_range(0, 1)) send_byte(CH_STAR);
        send_text("*/");
      end
      8: send_byte(CH_SLASH);
      9: send_byte(8'($urandom_range(0, 255)));
      10: begin
        // construct left open when the stream ends
        case ($urandom_range(0, 5))
          0: send_byte(CH_DQUOTE);
          1: send_byte(CH_SQUOTE);
          2: send_text("//");
          3: send_text("/*");
          4: send_text("/**");
          default: send_byte("x");
        endcase
        n = $urandom_range(0, 3);
        repeat (n) send_byte(rand_word_char());
        if ($urandom_range(0, 1)) send_byte(CH_BSLASH);
        send_byte(CH_NUL);
      end
      default: send_byte(CH_NUL);
    endcase
  endtask

  task automatic test_random_text();
    int phase;
    int phase_end;
    int start_cnt;
    start_cnt = bytes_sent;
    phase     = 0;
    while (bytes_sent - start_cnt < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin in_gap_max = 0;  out_gap_max = 0;  end
        1: begin in_gap_max = 19; out_gap_max = 0;  end
        2: begin in_gap_max = 0;  out_gap_max = 19; end
        default: begin in_gap_max = 19; out_gap_max = 19; end
      endcase
      phase_end = bytes_sent + 150;
      while (bytes_sent < phase_end) send_fragment();
      phase++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_gap_max  = 19;
    out_gap_max = 19;
    test_punctuation();
    test_identifiers();
    test_literals();
    test_comments();
    test_end_of_stream();

    test_random_text();

    char_in_valid_i <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d bytes, checked %0d tokens", bytes_sent, tokens_seen);
    $display("covered punctuation, identifiers, literals, comments, end of stream");
    $display("and random text with idle gaps on the byte and token sides");
    if (mismatch_cnt == 0 && tokens_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/csl_pkg.sv
hdl/csl_front.sv
hdl/csl_queue.sv
hdl/csl_back.sv
hdl/c_style_lexer_unit.sv
verif/tb_c_style_lexer_unit.sv
